[design/ufold_pkg.sv]
`default_nettype none

package ufold_pkg;

   localparam logic [7:0] LEAD_C3     = 8'hC3;
   localparam logic [7:0] LEAD2_MASK  = 8'hE0;
   localparam logic [7:0] LEAD2_CODE  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK  = 8'hF0;
   localparam logic [7:0] LEAD3_CODE  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK  = 8'hF8;
   localparam logic [7:0] LEAD4_CODE  = 8'hF0;
   localparam logic [7:0] CONT_MASK   = 8'hC0;
   localparam logic [7:0] CONT_CODE   = 8'h80;
   localparam logic [7:0] UPPER_FIRST = 8'h41;
   localparam logic [7:0] UPPER_LAST  = 8'h5A;
   localparam logic [6:0] CASE_BIT    = 7'h20;

   localparam logic [6:0] CHAR_A = 7'h61;
   localparam logic [6:0] CHAR_C = 7'h63;
   localparam logic [6:0] CHAR_E = 7'h65;
   localparam logic [6:0] CHAR_I = 7'h69;
   localparam logic [6:0] CHAR_N = 7'h6E;
   localparam logic [6:0] CHAR_O = 7'h6F;
   localparam logic [6:0] CHAR_U = 7'h75;
   localparam logic [6:0] CHAR_NONE = 7'h00;

   typedef struct packed {
      logic       has_byte;
      logic [6:0] out_byte;
      logic       out_last;
   } result_type;

   // Base letter for the byte after a 0xC3 lead; zero means drop.
   function automatic logic [6:0] fold_c3(input logic [7:0] d);
      logic [4:0] k;
      logic [6:0] ch;
      k  = d[4:0];
      ch = CHAR_NONE;
      if ((d & CONT_MASK) == CONT_CODE) begin
         case (k) inside
            [5'd0:5'd4]:   ch = CHAR_A;
            5'd7:          ch = CHAR_C;
            [5'd8:5'd11]:  ch = CHAR_E;
            [5'd12:5'd15]: ch = CHAR_I;
            5'd17:         ch = CHAR_N;
            [5'd18:5'd22]: ch = CHAR_O;
            [5'd25:5'd28]: ch = CHAR_U;
            default:       ch = CHAR_NONE;
         endcase
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

[design/ufold_step.sv]
`default_nettype none

module ufold_step (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  fire,
   input  wire logic [7:0]            in_byte,
   input  wire logic                  line_end,
   output ufold_pkg::result_type      result
);
   import ufold_pkg::*;

   logic       after_c3_ff, after_c3_in;
   logic [1:0] skip_ff, skip_in;
   logic [6:0] ch;
   logic       have;
   logic [6:0] fold_ch;

   assign fold_ch = fold_c3(in_byte);

   always_comb begin
      after_c3_in = after_c3_ff;
      skip_in     = skip_ff;
      ch          = CHAR_NONE;
      have        = 1'b0;
      if (fire) begin
         if (after_c3_ff) begin
            after_c3_in = 1'b0;
            ch          = fold_ch;
            have        = (fold_ch != CHAR_NONE);
         end else if (skip_ff != 2'd0) begin
            skip_in = skip_ff - 2'd1;
         end else if (!in_byte[7]) begin
            have = 1'b1;
            if (in_byte >= UPPER_FIRST && in_byte <= UPPER_LAST) begin
               ch = in_byte[6:0] | CASE_BIT;
            end else begin
               ch = in_byte[6:0];
            end
         end else if (in_byte == LEAD_C3) begin
            after_c3_in = 1'b1;
         end else if ((in_byte & LEAD2_MASK) == LEAD2_CODE) begin
            skip_in = 2'd1;
         end else if ((in_byte & LEAD3_MASK) == LEAD3_CODE) begin
            skip_in = 2'd2;
         end else if ((in_byte & LEAD4_MASK) == LEAD4_CODE) begin
            skip_in = 2'd3;
         end
         // end of line: drop whatever sequence is still open
         if (line_end) begin
            after_c3_in = 1'b0;
            skip_in     = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         after_c3_ff <= 1'b0;
         skip_ff     <= 2'd0;
      end else begin
         after_c3_ff <= after_c3_in;
         skip_ff     <= skip_in;
      end
   end

   assign result.has_byte = have;
   assign result.out_byte = ch;
   assign result.out_last = line_end;

`ifndef SYNTHESIS
   a_state_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(after_c3_ff && (skip_ff != 2'd0)))
      else $error("c3 decode and skip pending together");

   a_line_end_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && line_end) |=> (!after_c3_ff && (skip_ff == 2'd0)))
      else $error("state not cleared after line end");

   a_c3_consumes_one: assert property (@(posedge clock) disable iff (reset)
      (fire && after_c3_ff) |=> (!after_c3_ff && (skip_ff == 2'd0)))
      else $error("byte after c3 lead not consumed alone");

   a_skip_counts_down: assert property (@(posedge clock) disable iff (reset)
      (fire && !after_c3_ff && (skip_ff != 2'd0) && !line_end)
         |=> (skip_ff == $past(skip_ff) - 2'd1))
      else $error("skip count did not step down");
`endif

endmodule

`default_nettype wire

[design/utf8_accent_fold_lowercase_core.sv]
// UTF-8 accent folding to lower-case ASCII.
// Input channel req_: one raw UTF-8 byte per item (req_in_byte) with
// req_line_end marking the last byte of a line. Result channel rsp_: one
// item per input item, in order, carrying rsp_out_byte (7-bit ASCII, zero
// when not kept), rsp_has_byte and rsp_out_last (copy of line end).
// Both channels accept an item on a clock edge with valid high, stall low.
// An accepted byte moves from the input register to the result register
// once the result register is free to take it.
// Throughput: one item per cycle while rsp_stall is low; the fold and the
// 0xC3 flag and two-bit skip count update sit between the two registers.
// A stalled result holds in the result register while the input register
// may still take one further byte; req_stall rises only when both are full.
// Reset (synchronous, active high) empties both registers and clears the
// pending 0xC3 decode and the continuation-byte skip count.
`default_nettype none

module utf8_accent_fold_lowercase_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_line_end,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_out_byte,
   output logic            rsp_has_byte,
   output logic            rsp_out_last
);
   import ufold_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type step_result;
   logic       out_free;
   logic       step_fire;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step_fire = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_line_end;
      end
   end

   ufold_step u_step (
      .clock    (clock),
      .reset    (reset),
      .fire     (step_fire),
      .in_byte  (in_byte_ff),
      .line_end (in_last_ff),
      .result   (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   // hold the result while the receiver stalls
   always_ff @(posedge clock) begin
      if (step_fire) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_ff.out_byte;
   assign rsp_has_byte = rsp_ff.has_byte;
   assign rsp_out_last = rsp_ff.out_last;

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
   import ufold_pkg::*;

   typedef struct packed {
      logic [7:0] b;
      logic       e;
      logic       typed;
      logic       kept;
      logic [6:0] ch;
   } stim_row_type;

   typedef enum int unsigned {
      SEQ_ASCII, SEQ_ACCENT, SEQ_LEAD2, SEQ_LEAD3, SEQ_LEAD4, SEQ_NOISE
   } seq_kind_type;

   localparam int unsigned DIR_ROWS  = 25;
   localparam int unsigned PHASE_LEN = 265;

   // byte, line end, typed, kept, letter; untyped rows go through the predictor
   localparam stim_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, 7'h00},
      '{8'h7F, 1'b0, 1'b1, 1'b1, 7'h7F},
      '{8'h41, 1'b0, 1'b1, 1'b1, 7'h61},
      '{8'h5A, 1'b0, 1'b1, 1'b1, 7'h7A},
      '{8'h5B, 1'b0, 1'b1, 1'b1, 7'h5B},
      '{8'hC3, 1'b0, 1'b1, 1'b0, 7'h00},
      '{8'h80, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hBF, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'h41, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hC3, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hB1, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hE0, 1'b0, 1'b1, 1'b0, 7'h00},
      '{8'hFF, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'h00, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hF0, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'h7F, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hFF, 1'b1, 1'b1, 1'b0, 7'h00},
      '{8'h80, 1'b0, 1'b1, 1'b0, 7'h00},
      '{8'hF8, 1'b0, 1'b1, 1'b0, 7'h00},
      '{8'hDF, 1'b0, 1'b0, 1'b0, 7'h00},
      '{8'hC3, 1'b1, 1'b0, 1'b0, 7'h00},
      '{8'hC3, 1'b1, 1'b0, 1'b0, 7'h00},
      '{8'h80, 1'b1, 1'b1, 1'b0, 7'h00}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_line_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_out_last;

   // predictor state
   logic       c3_armed = 1'b0;
   logic [1:0] skip_left = 2'd0;

   result_type  pending_folds [$];
   int unsigned send_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   bit          want_long_hold = 1'b0;
   int unsigned bytes_sent = 0;
   int unsigned results_seen = 0;
   int unsigned kept_seen = 0;
   int unsigned line_ends = 0;
   int unsigned fails = 0;

   utf8_accent_fold_lowercase_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_line_end (req_line_end),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_has_byte (rsp_has_byte),
      .rsp_out_last (rsp_out_last)
   );

   always #1 clock = ~clock;

   function automatic result_type fold_predict(input logic [7:0] b, input logic e);
      result_type r;
      logic [4:0] k;
      r.has_byte = 1'b0;
      r.out_byte = CHAR_NONE;
      r.out_last = e;
      k = b[4:0];
      if (c3_armed) begin
         // the byte after 0xC3 is always consumed; only continuations map
         c3_armed = 1'b0;
         if ((b & CONT_MASK) == CONT_CODE) begin
            if (k <= 5'd4)                     r.out_byte = CHAR_A;
            else if (k == 5'd7)                r.out_byte = CHAR_C;
            else if (k >= 5'd8 && k <= 5'd11)  r.out_byte = CHAR_E;
            else if (k >= 5'd12 && k <= 5'd15) r.out_byte = CHAR_I;
            else if (k == 5'd17)               r.out_byte = CHAR_N;
            else if (k >= 5'd18 && k <= 5'd22) r.out_byte = CHAR_O;
            else if (k >= 5'd25 && k <= 5'd28) r.out_byte = CHAR_U;
         end
         r.has_byte = (r.out_byte != CHAR_NONE);
      end else if (skip_left != 2'd0) begin
         skip_left = skip_left - 2'd1;
      end else if (!b[7]) begin
         r.out_byte = b[6:0];
         if (b >= UPPER_FIRST && b <= UPPER_LAST) begin
            r.out_byte = b[6:0] | CASE_BIT;
         end
         r.has_byte = 1'b1;
      end else if (b == LEAD_C3) begin
         c3_armed = 1'b1;
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         skip_left = 2'd1;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         skip_left = 2'd2;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         skip_left = 2'd3;
      end
      if (e) begin
         c3_armed  = 1'b0;
         skip_left = 2'd0;
      end
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                            input result_type typed_want);
      result_type guess;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_byte  <= b;
      req_line_end <= e;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
      guess = fold_predict(b, e);
      pending_folds.push_back(typed ? typed_want : guess);
      bytes_sent++;
      if (e) line_ends++;
   endtask

   task automatic send_random(input logic [7:0] b);
      send_byte(b, ($urandom_range(15) == 0), 1'b0, '0);
   endtask

   // mostly a proper continuation, now and then any byte to break the sequence
   function automatic logic [7:0] cont_byte();
      if ($urandom_range(7) == 0) return 8'($urandom_range(255));
      return {2'b10, 6'($urandom_range(63))};
   endfunction

   initial begin : stimulus
      stim_row_type row;
      result_type   want;
      logic [7:0]   b;
      int unsigned  r;
      seq_kind_type kind;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         row = DIRECTED_ROWS[i];
         want.has_byte = row.kept;
         want.out_byte = row.ch;
         want.out_last = row.e;
         send_byte(row.b, row.e, row.typed, want);
      end

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin send_idle_pct = 24; rsp_idle_pct = 79; end
            1: begin send_idle_pct = 79; rsp_idle_pct = 24; end
            default: begin
               send_idle_pct  = 0;
               rsp_idle_pct   = 0;
               want_long_hold = 1'b1;
            end
         endcase
         while (bytes_sent < DIR_ROWS + (p + 1) * PHASE_LEN) begin
            r = $urandom_range(99);
            if (r < 35)      kind = SEQ_ASCII;
            else if (r < 60) kind = SEQ_ACCENT;
            else if (r < 70) kind = SEQ_LEAD2;
            else if (r < 80) kind = SEQ_LEAD3;
            else if (r < 88) kind = SEQ_LEAD4;
            else             kind = SEQ_NOISE;
            case (kind)
               SEQ_ASCII: begin
                  if ($urandom_range(1)) b = 8'($urandom_range(UPPER_LAST, UPPER_FIRST));
                  else b = 8'($urandom_range(127));
                  send_random(b);
               end
               SEQ_ACCENT: begin
                  send_random(LEAD_C3);
                  send_random(cont_byte());
               end
               SEQ_LEAD2: begin
                  do b = 8'($urandom_range(8'hDF, 8'hC0)); while (b == LEAD_C3);
                  send_random(b);
                  send_random(cont_byte());
               end
               SEQ_LEAD3: begin
                  send_random(8'($urandom_range(8'hEF, 8'hE0)));
                  repeat (2) send_random(cont_byte());
               end
               SEQ_LEAD4: begin
                  send_random(8'($urandom_range(8'hF7, 8'hF0)));
                  repeat (3) send_random(cont_byte());
               end
               default: send_random(8'($urandom_range(255)));
            endcase
         end
      end

      req_valid <= 1'b0;
      while (pending_folds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d bytes sent, %0d results checked, %0d kept, %0d line ends",
               bytes_sent, results_seen, kept_seen, line_ends);
      $display("covered case folding, 0xC3 decode, multi-byte skips, strays and cut lines");
      if (fails == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin : rsp_side
      int unsigned hold_cnt;
      hold_cnt = 0;
      forever begin
         @(posedge clock);
         if (hold_cnt != 0) begin
            hold_cnt--;
            rsp_stall <= 1'b1;
         end else if (want_long_hold) begin
            // hold off long enough for the block to fill and stall its input
            want_long_hold = 1'b0;
            hold_cnt = 47;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   always @(negedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_folds.size() == 0) begin
            $error("result item with no expectation waiting: out_byte %h has_byte %b",
                   rsp_out_byte, rsp_has_byte);
            fails++;
         end else begin
            want = pending_folds.pop_front();
            results_seen++;
            if (rsp_has_byte) kept_seen++;
            if (rsp_out_byte !== want.out_byte) begin
               $error("out_byte expected %h got %h", want.out_byte, rsp_out_byte);
               fails++;
            end
            if (rsp_has_byte !== want.has_byte) begin
               $error("has_byte expected %b got %b", want.has_byte, rsp_has_byte);
               fails++;
            end
            if (rsp_out_last !== want.out_last) begin
               $error("out_last expected %b got %b", want.out_last, rsp_out_last);
               fails++;
            end
         end
      end
   end

   initial begin : watchdog
      #200000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

[sim.f]
design/ufold_pkg.sv
design/ufold_step.sv
design/utf8_accent_fold_lowercase_core.sv
sim/tb_top.sv
